// File: sv/base64_stream_codec_assert.svh
// ----------------------------------------------------------------------------
// base64 stream codec assertion macros
// shared concurrent assertion forms used by the codec top level
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_ASSERT_SVH
`define BASE64_STREAM_CODEC_ASSERT_SVH

// same-cycle implication
`define B64SC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("base64 codec check failed");

// next-cycle implication
`define B64SC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("base64 codec check failed");

`endif

// File: sv/b64sc_pkg.sv
// ----------------------------------------------------------------------------
// b64sc_pkg
// types, constants and alphabet functions of the base64 stream codec
// ----------------------------------------------------------------------------
package b64sc_pkg;

   // results per input beat and derived widths
   localparam int MAX_RESULTS = 4;
   localparam int IDX_W       = $clog2(MAX_RESULTS);
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   // job queue depth default
   localparam int QUEUE_DEPTH = 2;

   // direction codes
   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   // ascii codes
   localparam logic [7:0] CHAR_PAD   = 8'h3D;
   localparam logic [7:0] CHAR_UPPER = 8'h41;
   localparam logic [7:0] CHAR_LOWER = 8'h61;
   localparam logic [7:0] CHAR_DIGIT = 8'h30;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   // one classified input beat: the result bytes it produces
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] chars;
      logic [CNT_W-1:0]            count;
      logic                        eom;
   } job_type;

   // decoded character
   typedef struct packed {
      logic       valid;
      logic [5:0] sextet;
   } sextet_type;

   // sextet to alphabet character
   function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
      logic [7:0] c;
      if (s < 6'd26) begin
         c = CHAR_UPPER + {2'b00, s};
      end else if (s < 6'd52) begin
         c = CHAR_LOWER + {2'b00, s} - 8'd26;
      end else if (s < 6'd62) begin
         c = CHAR_DIGIT + {2'b00, s} - 8'd52;
      end else if (s == 6'd62) begin
         c = CHAR_PLUS;
      end else begin
         c = CHAR_SLASH;
      end
      return c;
   endfunction

   // alphabet character to sextet, valid low outside the alphabet
   function automatic sextet_type char_to_sextet(input logic [7:0] c);
      sextet_type r;
      r.valid  = 1'b1;
      r.sextet = 6'd0;
      if (c >= CHAR_UPPER && c <= 8'h5A) begin
         r.sextet = 6'(c - CHAR_UPPER);
      end else if (c >= CHAR_LOWER && c <= 8'h7A) begin
         r.sextet = 6'(c - CHAR_LOWER + 8'd26);
      end else if (c >= CHAR_DIGIT && c <= 8'h39) begin
         r.sextet = 6'(c - CHAR_DIGIT + 8'd52);
      end else if (c == CHAR_PLUS) begin
         r.sextet = 6'd62;
      end else if (c == CHAR_SLASH) begin
         r.sextet = 6'd63;
      end else begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

endpackage

// File: sv/b64sc_req_if.sv
// ----------------------------------------------------------------------------
// b64sc_req_if
// input channel of the base64 stream codec: byte or character beats
// ----------------------------------------------------------------------------
interface b64sc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_in;
   logic       end_of_message;

   modport source (output valid, data_in, end_of_message, input ready);
   modport sink   (input valid, data_in, end_of_message, output ready);
endinterface

// File: sv/b64sc_rsp_if.sv
// ----------------------------------------------------------------------------
// b64sc_rsp_if
// result channel of the base64 stream codec: character or byte beats
// ----------------------------------------------------------------------------
interface b64sc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_out;
   logic       run_last;
   logic       message_done;

   modport source (output valid, data_out, run_last, message_done, input ready);
   modport sink   (input valid, data_out, run_last, message_done, output ready);
endinterface

// File: sv/b64sc_front.sv
// ----------------------------------------------------------------------------
// b64sc_front
// accepts input beats, keeps the stream state and builds a job of result bytes
// ----------------------------------------------------------------------------
module b64sc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_wdata,
   b64sc_req_if.sink         req,
   input  logic              q_ready,
   output logic              push,
   output b64sc_pkg::job_type push_job
);
   import b64sc_pkg::*;

   logic        direction_ff, direction_in;
   logic [15:0] held_bits_ff, held_bits_in;
   logic [1:0]  held_count_ff, held_count_in;
   logic        pad_seen_ff, pad_seen_in;

   logic        accept;
   logic [1:0]  enc_count;
   logic [23:0] group;
   logic [23:0] full;
   logic [11:0] bits;
   sextet_type  dec;
   job_type     job;

   assign req.ready = q_ready;
   assign accept    = req.valid & q_ready;

   // classify the beat and work out the next stream state
   always_comb begin
      direction_in  = direction_ff;
      held_bits_in  = held_bits_ff;
      held_count_in = held_count_ff;
      pad_seen_in   = pad_seen_ff;
      job           = '0;
      job.eom       = req.end_of_message;

      enc_count = (held_count_ff == 2'd3) ? 2'd2 : held_count_ff;
      group     = {held_bits_ff, req.data_in};
      full      = (enc_count == 2'd0) ? {req.data_in, 16'h0000}
                                      : {held_bits_ff[7:0], req.data_in, 8'h00};
      dec       = char_to_sextet(req.data_in);
      bits      = {held_bits_ff[5:0], dec.sextet};

      if (direction_ff == DIR_ENCODE) begin
         // encode: full group, flush with padding, or hold
         if (enc_count == 2'd2) begin
            job.chars[0]  = sextet_to_char(group[23:18]);
            job.chars[1]  = sextet_to_char(group[17:12]);
            job.chars[2]  = sextet_to_char(group[11:6]);
            job.chars[3]  = sextet_to_char(group[5:0]);
            job.count     = CNT_W'(MAX_RESULTS);
            held_bits_in  = '0;
            held_count_in = 2'd0;
         end else if (req.end_of_message) begin
            job.chars[0] = sextet_to_char(full[23:18]);
            job.chars[1] = sextet_to_char(full[17:12]);
            job.chars[2] = (enc_count == 2'd1) ? sextet_to_char(full[11:6]) : CHAR_PAD;
            job.chars[3] = CHAR_PAD;
            job.count    = CNT_W'(MAX_RESULTS);
         end else begin
            held_bits_in  = group[15:0];
            held_count_in = enc_count + 2'd1;
         end
      end else if (!pad_seen_ff) begin
         // decode: gather sextets, a byte out once eight bits are held
         if (req.data_in == CHAR_PAD) begin
            pad_seen_in = 1'b1;
         end else if (dec.valid) begin
            case (held_count_ff)
               2'd0: begin
                  held_bits_in  = {10'h000, dec.sextet};
                  held_count_in = 2'd3;
               end
               2'd3: begin
                  job.chars[0]  = bits[11:4];
                  job.count     = CNT_W'(1);
                  held_bits_in  = {12'h000, bits[3:0]};
                  held_count_in = 2'd2;
               end
               2'd2: begin
                  job.chars[0]  = bits[9:2];
                  job.count     = CNT_W'(1);
                  held_bits_in  = {14'h0000, bits[1:0]};
                  held_count_in = 2'd1;
               end
               default: begin
                  job.chars[0]  = bits[7:0];
                  job.count     = CNT_W'(1);
                  held_bits_in  = '0;
                  held_count_in = 2'd0;
               end
            endcase
         end
      end

      // message end returns the stream to its start
      if (req.end_of_message) begin
         held_bits_in  = '0;
         held_count_in = 2'd0;
         pad_seen_in   = 1'b0;
      end
   end

   assign push     = accept && (job.count != '0);
   assign push_job = job;

   // stream state, cleared by reset and by any direction write
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff  <= DIR_ENCODE;
         held_bits_ff  <= '0;
         held_count_ff <= 2'd0;
         pad_seen_ff   <= 1'b0;
      end else if (csr_we) begin
         direction_ff  <= csr_wdata;
         held_bits_ff  <= '0;
         held_count_ff <= 2'd0;
         pad_seen_ff   <= 1'b0;
      end else if (accept) begin
         direction_ff  <= direction_in;
         held_bits_ff  <= held_bits_in;
         held_count_ff <= held_count_in;
         pad_seen_ff   <= pad_seen_in;
      end
   end

endmodule

// File: sv/b64sc_queue.sv
// ----------------------------------------------------------------------------
// b64sc_queue
// short job queue between the front and back parts
// ----------------------------------------------------------------------------
module b64sc_queue #(
   parameter int DEPTH = b64sc_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64sc_pkg::job_type push_job,
   output logic              push_ready,
   input  logic              pop,
   output logic              pop_valid,
   output b64sc_pkg::job_type pop_job
);
   import b64sc_pkg::*;

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   job_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   assign push_ready = (fill_ff != FILL_W'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_job    = mem_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: sv/b64sc_back.sv
// ----------------------------------------------------------------------------
// b64sc_back
// takes jobs from the queue and sends their bytes one beat at a time
// ----------------------------------------------------------------------------
module b64sc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  b64sc_pkg::job_type q_job,
   output logic              pop,
   b64sc_rsp_if.source       rsp
);
   import b64sc_pkg::*;

   job_type          job_ff, job_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             busy_ff, busy_in;
   logic             last;
   logic             fire;

   assign last = ({1'b0, idx_ff} == CNT_W'(job_ff.count - CNT_W'(1)));
   assign fire = busy_ff & rsp.ready;
   assign pop  = q_valid & (!busy_ff | (fire & last));

   // result beat straight from the job register
   assign rsp.valid        = busy_ff;
   assign rsp.data_out     = job_ff.chars[idx_ff];
   assign rsp.run_last     = last;
   assign rsp.message_done = job_ff.eom;

   // step through the job, load the next one when idle or on the last beat
   always_comb begin
      job_in  = job_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (pop) begin
         job_in  = q_job;
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (fire) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      job_ff <= job_in;
   end

endmodule

// File: sv/base64_stream_codec.sv
// path: an accepted beat's job goes into the job queue, then into the job register
// of the back part; throughput: one result beat per cycle while rsp.ready is high;
// one input beat per cycle while each beat yields at most one result and the queue
// has room, so encoding is slowed by the single result port of the back part
// reset: synchronous, clears direction to encode, the stream state and the job queue
// ----------------------------------------------------------------------------
// base64_stream_codec
// streaming base64 encoder and decoder, standard alphabet, '=' padding
// ----------------------------------------------------------------------------
`include "base64_stream_codec_assert.svh"

module base64_stream_codec #(
   parameter int QUEUE_DEPTH = b64sc_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,
   b64sc_req_if.sink   req_ch,
   b64sc_rsp_if.source rsp_ch
);
   import b64sc_pkg::*;

   logic    q_push;
   logic    q_ready;
   logic    q_pop;
   logic    q_valid;
   job_type push_job;
   job_type pop_job;

   // front: accept and classify beats
   b64sc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req_ch),
      .q_ready   (q_ready),
      .push      (q_push),
      .push_job  (push_job)
   );

   // job queue
   b64sc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (push_job),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_job    (pop_job)
   );

   // back: send result beats
   b64sc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_job   (pop_job),
      .pop     (q_pop),
      .rsp     (rsp_ch)
   );

   // checks
   `B64SC_ASSERT_NOW(a_no_overflow, clock, reset, q_push, q_ready)
   `B64SC_ASSERT_NOW(a_no_underflow, clock, reset, q_pop, q_valid)
   `B64SC_ASSERT_NOW(a_job_nonempty, clock, reset, q_push, push_job.count != '0)
   `B64SC_ASSERT_NOW(a_job_bound, clock, reset, q_push, push_job.count <= CNT_W'(MAX_RESULTS))
   `B64SC_ASSERT_NEXT(a_pop_shows, clock, reset, q_pop, rsp_ch.valid)

endmodule

// File: dv/tb_base64_stream_codec.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_base64_stream_codec
// self-checking bench for the streaming base64 codec: a directed table of
// known encodings, decodings, padding and skipped characters, then random
// messages in both directions under random stalls on both channels, each
// result beat checked against a typed answer or a bit-level model kept in the bench
// ----------------------------------------------------------------------------
module tb_base64_stream_codec;
   import b64sc_pkg::*;

   // run limits
   localparam int CYCLE_LIMIT  = 300000;
   localparam int SETTLE_CYC   = 8;
   localparam int PHASE_BEATS  = 24;
   localparam int NUM_PHASES   = 6;

   // standard alphabet, sextet 0 in the top byte
   localparam logic [8*64-1:0] B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct {
      logic [7:0] data_out;
      logic       run_last;
      logic       message_done;
   } rsp_beat_type;

   // one directed row; typed_n below zero means take the model's answer
   typedef struct {
      logic        dir;
      logic [7:0]  data;
      logic        eom;
      int          typed_n;
      logic [31:0] typed;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   b64sc_req_if req_bus ();
   b64sc_rsp_if rsp_bus ();

   base64_stream_codec uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_bus.sink),
      .rsp_ch    (rsp_bus.source)
   );

   // codec model state
   logic        codec_dir;
   logic [15:0] hold_bits;
   logic [1:0]  hold_cnt;
   logic        pad_hit;

   rsp_beat_type pending_rsp[$];
   stim_row_type rows[$];
   int           error_count;
   int           beats_sent;
   int           rsp_checked;
   int           msgs_closed;
   int           dir_writes;
   int           cycle_count;
   bit           quiet;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // gap length: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // append one expected result beat
   function automatic void expect_rsp(input logic [7:0] data, input logic last,
                                      input logic done);
      rsp_beat_type b;
      b.data_out     = data;
      b.run_last     = last;
      b.message_done = done;
      pending_rsp.insert(pending_rsp.size(), b);
   endfunction

   // append one directed row
   function automatic void add_row(input logic dir, input logic [7:0] data,
                                   input logic eom, input int typed_n,
                                   input logic [31:0] typed);
      stim_row_type s;
      s.dir     = dir;
      s.data    = data;
      s.eom     = eom;
      s.typed_n = typed_n;
      s.typed   = typed;
      rows.insert(rows.size(), s);
   endfunction

   function automatic logic [7:0] alpha_char(input logic [5:0] s);
      int k;
      k = 63 - int'(s);
      return B64_ALPHABET[8*k +: 8];
   endfunction

   // bit 6 set when the character is outside the alphabet
   function automatic logic [6:0] char_sextet(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) return {1'b0, 6'(c - 8'h41)};
      if (c >= 8'h61 && c <= 8'h7A) return {1'b0, 6'(c - 8'h61 + 8'd26)};
      if (c >= 8'h30 && c <= 8'h39) return {1'b0, 6'(c - 8'h30 + 8'd52)};
      if (c == 8'h2B) return {1'b0, 6'd62};
      if (c == 8'h2F) return {1'b0, 6'd63};
      return 7'h40;
   endfunction

   // result bytes of one input beat, first byte in chars[31:24]; updates model state
   function automatic int next_codec_chars(input logic [7:0] d, input logic e,
                                           output logic [31:0] chars);
      logic [1:0]  cnt;
      logic [23:0] grp;
      logic [23:0] full;
      logic [11:0] bits;
      logic [6:0]  sx;
      int          nbits;
      int          n;
      n = 0;
      chars = '0;
      if (codec_dir == DIR_ENCODE) begin
         cnt = (hold_cnt > 2'd2) ? 2'd2 : hold_cnt;
         grp = {hold_bits, d};
         if (cnt == 2'd2) begin
            chars = {alpha_char(grp[23:18]), alpha_char(grp[17:12]),
                     alpha_char(grp[11:6]), alpha_char(grp[5:0])};
            n = 4;
            hold_bits = '0;
            hold_cnt = '0;
         end else if (e) begin
            full = (cnt == 2'd1) ? (grp << 8) : (grp << 16);
            chars = {alpha_char(full[23:18]), alpha_char(full[17:12]),
                     (cnt == 2'd1) ? alpha_char(full[11:6]) : CHAR_PAD, CHAR_PAD};
            n = 4;
         end else begin
            hold_bits = grp[15:0];
            hold_cnt = cnt + 2'd1;
         end
      end else if (!pad_hit) begin
         if (d == CHAR_PAD) begin
            pad_hit = 1'b1;
         end else begin
            sx = char_sextet(d);
            if (!sx[6]) begin
               nbits = int'(hold_cnt) * 2 + 6;
               bits = {hold_bits[5:0], sx[5:0]};
               if (nbits >= 8) begin
                  chars[31:24] = 8'(bits >> (nbits - 8));
                  n = 1;
                  nbits = nbits - 8;
               end
               hold_bits = {4'b0, bits} & ((16'd1 << nbits) - 16'd1);
               hold_cnt = 2'(nbits / 2);
            end
         end
      end
      if (e) begin
         hold_bits = '0;
         hold_cnt = '0;
         pad_hit = 1'b0;
      end
      return n;
   endfunction

   // one input beat: optional idle gap, handshake, then queue its results
   task automatic send_beat(input logic [7:0] d, input logic e, input int gap,
                            input int typed_n, input logic [31:0] typed);
      logic [31:0] chars;
      int          n;
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.data_in <= d;
      req_bus.end_of_message <= e;
      do @(posedge clock); while (!req_bus.ready);
      n = next_codec_chars(d, e, chars);
      if (typed_n >= 0) begin
         n = typed_n;
         chars = typed;
      end
      for (int i = 0; i < n; i++) begin
         expect_rsp(chars[31-8*i -: 8], (i == n - 1), e);
      end
      beats_sent++;
      if (e) msgs_closed++;
   endtask

   // hold the sender until every expected beat has come and the block settles
   task automatic wait_for_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_direction(input logic v);
      wait_for_results();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      codec_dir = v;
      hold_bits = '0;
      hold_cnt = '0;
      pad_hit = 1'b0;
      dir_writes++;
   endtask

   // result side: random stalls
   initial begin
      int stall;
      stall = 0;
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < 25) stall = pick_gap();
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result beat data_out=%h run_last=%b message_done=%b",
                     $time, rsp_bus.data_out, rsp_bus.run_last, rsp_bus.message_done);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_bus.data_out !== want.data_out || rsp_bus.run_last !== want.run_last ||
                rsp_bus.message_done !== want.message_done) begin
               $display("%0t: mismatch expected data_out=%h run_last=%b message_done=%b",
                        $time, want.data_out, want.run_last, want.message_done);
               $display("%0t:          actual   data_out=%h run_last=%b message_done=%b",
                        $time, rsp_bus.data_out, rsp_bus.run_last, rsp_bus.message_done);
               error_count++;
            end
            rsp_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still expected",
                  cycle_count, pending_rsp.size());
         $display("FAILURE");
         $finish;
      end
   end

   // stimulus
   initial begin
      logic        phase_dir[NUM_PHASES];
      logic [7:0]  d;
      int          budget;
      int          len;
      int          r;
      logic        first_msg;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.data_in = '0;
      req_bus.end_of_message = 1'b0;
      codec_dir = DIR_ENCODE;
      hold_bits = '0;
      hold_cnt = '0;
      pad_hit = 1'b0;
      error_count = 0;
      beats_sent = 0;
      rsp_checked = 0;
      msgs_closed = 0;
      dir_writes = 0;
      quiet = 1'b0;

      // encode: single byte, all ones, classic group, two-byte pad, mid-stream group
      add_row(DIR_ENCODE, 8'h00, 1'b1, 4, "AA==");
      add_row(DIR_ENCODE, 8'hFF, 1'b0, 0, 32'h0);
      add_row(DIR_ENCODE, 8'hFF, 1'b0, 0, 32'h0);
      add_row(DIR_ENCODE, 8'hFF, 1'b1, 4, "////");
      add_row(DIR_ENCODE, "M",   1'b0, 0, 32'h0);
      add_row(DIR_ENCODE, "a",   1'b0, 0, 32'h0);
      add_row(DIR_ENCODE, "n",   1'b1, 4, "TWFu");
      add_row(DIR_ENCODE, 8'hFF, 1'b0, 0, 32'h0);
      add_row(DIR_ENCODE, 8'hFF, 1'b1, 4, "//8=");
      add_row(DIR_ENCODE, 8'h00, 1'b0, -1, 32'h0);
      add_row(DIR_ENCODE, 8'h00, 1'b0, -1, 32'h0);
      add_row(DIR_ENCODE, 8'h00, 1'b0, 4, "AAAA");
      add_row(DIR_ENCODE, 8'h80, 1'b1, -1, 32'h0);
      // decode: known text, skipped characters, plus and slash, pad then ignored end
      add_row(DIR_DECODE, "T",   1'b0, 0, 32'h0);
      add_row(DIR_DECODE, "W",   1'b0, 1, {"M", 24'h0});
      add_row(DIR_DECODE, "F",   1'b0, 1, {"a", 24'h0});
      add_row(DIR_DECODE, "u",   1'b1, 1, {"n", 24'h0});
      add_row(DIR_DECODE, "*",   1'b0, -1, 32'h0);
      add_row(DIR_DECODE, 8'h00, 1'b0, -1, 32'h0);
      add_row(DIR_DECODE, 8'hFF, 1'b0, -1, 32'h0);
      add_row(DIR_DECODE, "+",   1'b0, -1, 32'h0);
      add_row(DIR_DECODE, "/",   1'b1, 1, 32'hFB00_0000);
      add_row(DIR_DECODE, "z",   1'b0, -1, 32'h0);
      add_row(DIR_DECODE, "9",   1'b0, -1, 32'h0);
      add_row(DIR_DECODE, "=",   1'b0, 0, 32'h0);
      add_row(DIR_DECODE, "A",   1'b1, 0, 32'h0);

      // both extremes, a repeated write of the same value
      phase_dir[0] = DIR_ENCODE;
      phase_dir[1] = DIR_DECODE;
      phase_dir[2] = DIR_DECODE;
      phase_dir[3] = DIR_ENCODE;
      phase_dir[4] = DIR_DECODE;
      phase_dir[5] = DIR_ENCODE;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (rows[i]) begin
         if (rows[i].dir != codec_dir) write_direction(rows[i].dir);
         send_beat(rows[i].data, rows[i].eom, pick_gap(), rows[i].typed_n, rows[i].typed);
      end

      // random messages, one direction per phase
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_direction(phase_dir[p]);
         quiet = (p == 2);
         budget = PHASE_BEATS;
         first_msg = 1'b1;
         while (budget > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 10);
            for (int i = 0; i < len && budget > 0; i++) begin
               if (codec_dir == DIR_ENCODE) begin
                  d = 8'($urandom_range(0, 255));
               end else begin
                  // mostly alphabet text, pad near the end, some noise
                  r = $urandom_range(0, 99);
                  if (r < 8) d = 8'($urandom_range(0, 255));
                  else if (i >= len - 2 && r < 33) d = CHAR_PAD;
                  else if (r < 12) d = CHAR_PAD;
                  else d = alpha_char(6'($urandom_range(0, 63)));
               end
               send_beat(d, (i == len - 1), quiet ? 0 : pick_gap(), -1, 32'h0);
               budget--;
            end
            if ((p == 3 && first_msg) || $urandom_range(0, 99) < 5) wait_for_results();
            first_msg = 1'b0;
         end
      end

      quiet = 1'b0;
      wait_for_results();
      repeat (20) @(posedge clock);

      $display("sent %0d beats in %0d closed messages over %0d direction writes",
               beats_sent, msgs_closed, dir_writes);
      $display("checked %0d result beats, %0d errors", rsp_checked, error_count);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
